>>> rtl/prte_pkg.sv
// Shared types, constants and base-91 helpers for the packet-rate telemetry encoder.
`default_nettype none

package prte_pkg;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned NUM_W  = 54;
  localparam int unsigned VAL_W  = 14;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned MSH_W  = 22;

  localparam logic [MSH_W-1:0]  MS_PER_HOUR = 22'd3600000;
  localparam logic [VAL_W-1:0]  RATE_MAX    = 14'd8280;
  localparam logic [VAL_W-1:0]  SEQ_LAST    = 14'd8280;
  localparam logic [CHAR_W-1:0] B91_OFFSET  = 7'd33;
  localparam logic [VAL_W-1:0]  B91_BASE    = 14'd91;

  // Reciprocal of 91 scaled by 2^20; exact for every value below 61680.
  localparam logic [14:0]       B91_RECIP   = 15'd11523;
  localparam int unsigned       B91_SHIFT   = 20;

  typedef enum logic [1:0] {
    OP_RX     = 2'd0,
    OP_RELAY  = 2'd1,
    OP_DROP   = 2'd2,
    OP_REPORT = 2'd3
  } opcode_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_ENC  = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_WAIT = 7'b1000000
  } state_e;

  // Divider handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

  // High base-91 digit of a value below 8281.
  function automatic logic [CHAR_W-1:0] b91_high(input logic [VAL_W-1:0] v);
    logic [28:0] p;
    p = {15'd0, v} * {14'd0, B91_RECIP};
    return p[B91_SHIFT +: CHAR_W];
  endfunction

  // Low base-91 digit, given the value and its high digit.
  function automatic logic [CHAR_W-1:0] b91_low(input logic [VAL_W-1:0] v,
                                                input logic [CHAR_W-1:0] hi);
    logic [VAL_W-1:0] r;
    r = v - ({{(VAL_W-CHAR_W){1'b0}}, hi} * B91_BASE);
    return r[CHAR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/packet_rate_telemetry_encoder.sv
// Packet-rate telemetry encoder: event counters, hourly rates and base-91 report output.
//
// Event requests (received, relayed, dropped) are taken back to back while idle and
// bump saturating 32-bit counters. A report request keeps the input stalled until its
// report is loaded into the output register. For each of the three counters a multiply
// by 3600000 and a rounding add feed a 54-step serial divider, which all three share.
// After the last counter the high digits are encoded, a wait state follows and the
// output register is loaded. A report with zero elapsed time skips the divider. A
// report also waits longer while an earlier one is still held in the output register.
// The finished report sits in that output register, so further requests are taken
// while it waits to be collected.
`default_nettype none

module packet_rate_telemetry_encoder import prte_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [31:0]       now_ms_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      seq_high_char_o,
  output logic [CHAR_W-1:0]      seq_low_char_o,
  output logic [CHAR_W-1:0]      rx_high_char_o,
  output logic [CHAR_W-1:0]      rx_low_char_o,
  output logic [CHAR_W-1:0]      relay_high_char_o,
  output logic [CHAR_W-1:0]      relay_low_char_o,
  output logic [CHAR_W-1:0]      drop_high_char_o,
  output logic [CHAR_W-1:0]      drop_low_char_o
);

  state_e            state_q, state_d;
  logic [1:0]        ch_q, ch_d;
  logic [CNT_W-1:0]  rx_cnt_q, rx_cnt_d;
  logic [CNT_W-1:0]  relay_cnt_q, relay_cnt_d;
  logic [CNT_W-1:0]  drop_cnt_q, drop_cnt_d;
  logic [CNT_W-1:0]  win_start_q, win_start_d;
  logic [CNT_W-1:0]  elapsed_q, elapsed_d;
  logic [VAL_W-1:0]  seq_q, seq_d;
  logic              out_valid_q, out_valid_d;

  logic [NUM_W-1:0]  prod_q;
  logic [VAL_W-1:0]  rate_q [3];
  logic [CHAR_W-1:0] hi_q [4];
  logic [CHAR_W-1:0] out_hi_q [4];
  logic [CHAR_W-1:0] out_lo_q [4];

  logic [VAL_W-1:0]  vals [4];
  logic [CNT_W-1:0]  cnt_sel;
  logic [NUM_W-1:0]  numer;
  logic [VAL_W-1:0]  rate_sat;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              last_ch;
  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  logic [NUM_W-1:0]  div_quot;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_OUT) && out_free;
  assign last_ch    = (ch_q == 2'd2);

  assign vals[0] = seq_q;
  assign vals[1] = rate_q[0];
  assign vals[2] = rate_q[1];
  assign vals[3] = rate_q[2];

  always_comb begin
    case (ch_q)
      2'd0:    cnt_sel = rx_cnt_q;
      2'd1:    cnt_sel = relay_cnt_q;
      default: cnt_sel = drop_cnt_q;
    endcase
  end

  // Rounding: half the elapsed time is added before the division.
  assign numer         = prod_q + {{(NUM_W-CNT_W+1){1'b0}}, elapsed_q[CNT_W-1:1]};
  assign div_ctrl.start = (state_q == ST_ADD);

  assign rate_sat = ((|div_quot[NUM_W-1:VAL_W]) || (div_quot[VAL_W-1:0] > RATE_MAX))
                    ? RATE_MAX : div_quot[VAL_W-1:0];

  prte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .numer_i (numer),
    .denom_i (elapsed_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    rx_cnt_d    = rx_cnt_q;
    relay_cnt_d = relay_cnt_q;
    drop_cnt_d  = drop_cnt_q;
    win_start_d = win_start_q;
    elapsed_d   = elapsed_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (opcode_e'(opcode_i))
            OP_RX:    rx_cnt_d    = (&rx_cnt_q)    ? rx_cnt_q    : rx_cnt_q + 1'b1;
            OP_RELAY: relay_cnt_d = (&relay_cnt_q) ? relay_cnt_q : relay_cnt_q + 1'b1;
            OP_DROP:  drop_cnt_d  = (&drop_cnt_q)  ? drop_cnt_q  : drop_cnt_q + 1'b1;
            default: begin
              elapsed_d   = now_ms_i - win_start_q;
              win_start_d = now_ms_i;
              ch_d        = 2'd0;
              state_d     = ST_MUL;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (elapsed_q == '0) begin
          ch_d    = ch_q + 1'b1;
          state_d = last_ch ? ST_ENC : ST_MUL;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ch_d    = ch_q + 1'b1;
          state_d = last_ch ? ST_ENC : ST_MUL;
        end
      end
      ST_ENC: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rx_cnt_d    = '0;
          relay_cnt_d = '0;
          drop_cnt_d  = '0;
          seq_d       = (seq_q == SEQ_LAST) ? '0 : seq_q + 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      rx_cnt_q    <= '0;
      relay_cnt_q <= '0;
      drop_cnt_q  <= '0;
      win_start_q <= '0;
      elapsed_q   <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      rx_cnt_q    <= rx_cnt_d;
      relay_cnt_q <= relay_cnt_d;
      drop_cnt_q  <= drop_cnt_d;
      win_start_q <= win_start_d;
      elapsed_q   <= elapsed_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers: product, rates, high digits and the output report.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= {{(NUM_W-CNT_W){1'b0}}, cnt_sel}
                * {{(NUM_W-MSH_W){1'b0}}, MS_PER_HOUR};
      if (elapsed_q == '0) begin
        rate_q[ch_q] <= '0;
      end
    end
    if ((state_q == ST_DIV) && div_stat.done) begin
      rate_q[ch_q] <= rate_sat;
    end
    if (state_q == ST_ENC) begin
      for (int i = 0; i < 4; i++) begin
        hi_q[i] <= b91_high(vals[i]);
      end
    end
    if (out_load) begin
      for (int i = 0; i < 4; i++) begin
        out_hi_q[i] <= hi_q[i] + B91_OFFSET;
        out_lo_q[i] <= b91_low(vals[i], hi_q[i]) + B91_OFFSET;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign seq_high_char_o   = out_hi_q[0];
  assign seq_low_char_o    = out_lo_q[0];
  assign rx_high_char_o    = out_hi_q[1];
  assign rx_low_char_o     = out_lo_q[1];
  assign relay_high_char_o = out_hi_q[2];
  assign relay_low_char_o  = out_lo_q[2];
  assign drop_high_char_o  = out_hi_q[3];
  assign drop_low_char_o   = out_lo_q[3];

endmodule

`default_nettype wire

>>> rtl/prte_div.sv
// Restoring serial divider: one quotient bit per cycle.
`default_nettype none

module prte_div import prte_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_ctrl_t        ctrl_i,
  input  wire logic [NUM_W-1:0] numer_i,
  input  wire logic [CNT_W-1:0] denom_i,
  output div_stat_t             stat_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  den_q, den_d;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W+1:0]  diff;
  logic              fits;

  // The partial remainder stays below the divisor, so 33 bits hold the shifted value.
  assign rem_sh = {rem_q[CNT_W-1:0], quo_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = ~diff[CNT_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W - 1);
      rem_d  = '0;
      quo_d  = numer_i;
      den_d  = denom_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[CNT_W:0] : rem_sh;
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

`default_nettype wire

>>> tb/tb_packet_rate_telemetry_encoder.sv
// Self-checking testbench for the packet-rate telemetry encoder.
`timescale 1ns / 100ps

module tb_packet_rate_telemetry_encoder import prte_pkg::*; ();

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_SHOWN = 30;
  localparam logic [63:0] HOUR_MS = 64'd3600000;
  localparam logic [63:0] RATE_CAP = 64'd8280;
  localparam int unsigned DIGIT_BASE = 91;
  localparam int unsigned DIGIT_OFFSET = 33;
  localparam logic [13:0] SEQ_TOP = 14'd8280;

  typedef struct packed {
    logic [6:0] seq_hi;
    logic [6:0] seq_lo;
    logic [6:0] rx_hi;
    logic [6:0] rx_lo;
    logic [6:0] relay_hi;
    logic [6:0] relay_lo;
    logic [6:0] drop_hi;
    logic [6:0] drop_lo;
  } report_t;

  typedef struct {
    opcode_e     op;
    logic [31:0] now;
    bit          typed;
    report_t     want;
  } dir_row_t;

  localparam report_t NOT_TYPED = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [1:0]  opcode;
  logic [31:0] now_ms;
  logic        out_stall;
  wire         in_stall;
  wire         out_valid;
  wire report_t dut_report;

  packet_rate_telemetry_encoder i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .now_ms_i          (now_ms),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .seq_high_char_o   (dut_report.seq_hi),
    .seq_low_char_o    (dut_report.seq_lo),
    .rx_high_char_o    (dut_report.rx_hi),
    .rx_low_char_o     (dut_report.rx_lo),
    .relay_high_char_o (dut_report.relay_hi),
    .relay_low_char_o  (dut_report.relay_lo),
    .drop_high_char_o  (dut_report.drop_hi),
    .drop_low_char_o   (dut_report.drop_lo)
  );

  // Shadow copy of the block's counters, window and sequence.
  logic [31:0] rx_tally;
  logic [31:0] relay_tally;
  logic [31:0] drop_tally;
  logic [31:0] window_ms;
  logic [13:0] report_seq;

  report_t     pending_reports[$];
  dir_row_t    dir_table[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned req_count;
  int unsigned reports_checked;
  int unsigned seq_wraps;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] sat_bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? {32'd0, v} : {32'd0, v} + 64'd1;
  endfunction

  function automatic logic [13:0] hourly_rate(logic [31:0] count, logic [31:0] span);
    logic [63:0] q;
    if (span == 32'd0) return 14'd0;
    q = ({32'd0, count} * HOUR_MS + {33'd0, span[31:1]}) / {32'd0, span};
    if (q > RATE_CAP) q = RATE_CAP;
    return q[13:0];
  endfunction

  // Two base-91 digits as printable characters, high digit first.
  function automatic logic [13:0] digit_pair(logic [13:0] v);
    int unsigned hi;
    int unsigned lo;
    hi = int'(v) / DIGIT_BASE + DIGIT_OFFSET;
    lo = int'(v) % DIGIT_BASE + DIGIT_OFFSET;
    return {hi[6:0], lo[6:0]};
  endfunction

  task automatic predict_request(input opcode_e op, input logic [31:0] now,
                                 output bit emits, output report_t rep);
    logic [31:0] span;
    logic [13:0] seq;
    logic [63:0] bumped;
    emits = 1'b0;
    rep = '0;
    case (op)
      OP_RX: begin
        bumped = sat_bump(rx_tally);
        rx_tally = bumped[31:0];
      end
      OP_RELAY: begin
        bumped = sat_bump(relay_tally);
        relay_tally = bumped[31:0];
      end
      OP_DROP: begin
        bumped = sat_bump(drop_tally);
        drop_tally = bumped[31:0];
      end
      default: begin
        span = now - window_ms;
        seq = (report_seq > SEQ_TOP) ? report_seq - (SEQ_TOP + 14'd1) : report_seq;
        {rep.seq_hi, rep.seq_lo} = digit_pair(seq);
        {rep.rx_hi, rep.rx_lo} = digit_pair(hourly_rate(rx_tally, span));
        {rep.relay_hi, rep.relay_lo} = digit_pair(hourly_rate(relay_tally, span));
        {rep.drop_hi, rep.drop_lo} = digit_pair(hourly_rate(drop_tally, span));
        rx_tally = '0;
        relay_tally = '0;
        drop_tally = '0;
        window_ms = now;
        if (seq == SEQ_TOP) begin
          report_seq = '0;
          seq_wraps++;
        end else begin
          report_seq = seq + 14'd1;
        end
        emits = 1'b1;
      end
    endcase
  endtask

  // Entered just after a falling edge; returns just after a falling edge.
  task automatic send_request(input opcode_e op, input logic [31:0] now,
                              input bit typed, input report_t want);
    bit      emits;
    report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, now, emits, rep);
    req_count++;
    if (emits) pending_reports = {pending_reports, (typed ? want : rep)};
    @(negedge clk);
  endtask

  task automatic add_row(input opcode_e op, input logic [31:0] now,
                         input bit typed, input report_t want);
    dir_row_t r;
    r.op = op;
    r.now = now;
    r.typed = typed;
    r.want = want;
    dir_table = {dir_table, r};
  endtask

  // Windows of random events closed by a report whose elapsed time is drawn
  // from zero, very short (often saturating), realistic and fully random spans.
  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned n_events;
    int unsigned mode;
    logic [31:0] span;
    logic [31:0] at;
    stop_at = req_count + n_items;
    while (req_count < stop_at) begin
      n_events = $urandom_range(0, 15);
      repeat (n_events) begin
        send_request(opcode_e'($urandom_range(0, 2)), $urandom(), 1'b0, NOT_TYPED);
      end
      mode = $urandom_range(0, 9);
      case (mode)
        0: span = 32'd0;
        1: span = $urandom_range(1, 1000);
        2: span = $urandom();
        default: span = $urandom_range(435, 8000000);
      endcase
      at = (mode == 3) ? $urandom() : window_ms + span;
      send_request(OP_REPORT, at, 1'b0, NOT_TYPED);
    end
  endtask

  task automatic check_char(input string name, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("%0t: report with none expected, expected nothing, actual %h",
                   $time, dut_report);
        end
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        check_char("seq_high_char", want.seq_hi, dut_report.seq_hi);
        check_char("seq_low_char", want.seq_lo, dut_report.seq_lo);
        check_char("rx_high_char", want.rx_hi, dut_report.rx_hi);
        check_char("rx_low_char", want.rx_lo, dut_report.rx_lo);
        check_char("relay_high_char", want.relay_hi, dut_report.relay_hi);
        check_char("relay_low_char", want.relay_lo, dut_report.relay_lo);
        check_char("drop_high_char", want.drop_hi, dut_report.drop_hi);
        check_char("drop_low_char", want.drop_lo, dut_report.drop_lo);
      end
    end
  end

  // A run that stops moving requests in either direction is a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    opcode = OP_RX;
    now_ms = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req_count = 0;
    reports_checked = 0;
    seq_wraps = 0;
    mismatches = 0;
    quiet_cycles = 0;
    rx_tally = '0;
    relay_tally = '0;
    drop_tally = '0;
    window_ms = '0;
    report_seq = '0;

    // First report straight after reset: zero elapsed, so every rate is zero.
    add_row(OP_REPORT, 32'd0, 1'b1, '{7'd33, 7'd33, 7'd33, 7'd33, 7'd33, 7'd33, 7'd33, 7'd33});
    add_row(OP_RX, 32'hFFFF_FFFF, 1'b0, NOT_TYPED);
    add_row(OP_RELAY, 32'd0, 1'b0, NOT_TYPED);
    add_row(OP_DROP, 32'h5555_5555, 1'b0, NOT_TYPED);
    // One event in one millisecond saturates every rate.
    add_row(OP_REPORT, 32'd1, 1'b1,
            '{7'd33, 7'd34, 7'd123, 7'd123, 7'd123, 7'd123, 7'd123, 7'd123});
    add_row(OP_RX, 32'hAAAA_AAAA, 1'b0, NOT_TYPED);
    add_row(OP_RX, 32'd0, 1'b0, NOT_TYPED);
    // Zero elapsed time with events counted still gives zero rates.
    add_row(OP_REPORT, 32'd1, 1'b1, '{7'd33, 7'd35, 7'd33, 7'd33, 7'd33, 7'd33, 7'd33, 7'd33});
    add_row(OP_RX, 32'd0, 1'b0, NOT_TYPED);
    add_row(OP_REPORT, 32'd3600001, 1'b1,
            '{7'd33, 7'd36, 7'd33, 7'd34, 7'd33, 7'd33, 7'd33, 7'd33});
    // Rounding right at one half, then just below it.
    add_row(OP_DROP, 32'd0, 1'b0, NOT_TYPED);
    add_row(OP_REPORT, 32'd10800001, 1'b0, NOT_TYPED);
    add_row(OP_DROP, 32'd0, 1'b0, NOT_TYPED);
    add_row(OP_REPORT, 32'd18000002, 1'b0, NOT_TYPED);
    // Just under and just over the rate ceiling.
    add_row(OP_RELAY, 32'd0, 1'b0, NOT_TYPED);
    add_row(OP_REPORT, 32'd18000437, 1'b0, NOT_TYPED);
    add_row(OP_RELAY, 32'd0, 1'b0, NOT_TYPED);
    add_row(OP_REPORT, 32'd18000871, 1'b0, NOT_TYPED);
    // Time running past the top of the 32-bit range.
    add_row(OP_REPORT, 32'hFFFF_FFFF, 1'b0, NOT_TYPED);
    add_row(OP_RX, 32'h0000_FFFF, 1'b0, NOT_TYPED);
    add_row(OP_RX, 32'hFFFF_0000, 1'b0, NOT_TYPED);
    add_row(OP_REPORT, 32'd5, 1'b0, NOT_TYPED);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_table[i]) begin
      send_request(dir_table[i].op, dir_table[i].now, dir_table[i].typed, dir_table[i].want);
    end

    run_random(400);
    send_idle_pct = 87;
    run_random(400);
    send_idle_pct = 0;
    recv_stall_pct = 87;
    run_random(400);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    run_random(400);

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d reports checked under four idling patterns",
             req_count, reports_checked);
    $display("sequence wrapped %0d time(s), %0d mismatches", seq_wraps, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
